// ===== hw/rtl/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// stok_pkg
// Shared widths, quoting-mode codes, token-kind codes and character constants
// for the shell word character tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stok_pkg;

  // Field widths
  localparam int MODE_W  = 4;
  localparam int AVAIL_W = 2;
  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 5;
  localparam int COUNT_W = 2;
  localparam int MODES   = 9;

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [AVAIL_W-1:0] avail_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [MODES-1:0]   mode_mask_t;

  // Quoting modes
  localparam mode_t MODE_UNQ = 4'd0;
  localparam mode_t MODE_SGL = 4'd1;
  localparam mode_t MODE_DBL = 4'd2;
  localparam mode_t MODE_BTK = 4'd3;
  localparam mode_t MODE_EXP = 4'd4;
  localparam mode_t MODE_ARI = 4'd5;
  localparam mode_t MODE_AGR = 4'd6;
  localparam mode_t MODE_ESB = 4'd7;
  localparam mode_t MODE_SUB = 4'd8;

  // One-hot mode masks
  localparam mode_mask_t MASK_UNQ = 9'h001;
  localparam mode_mask_t MASK_SGL = 9'h002;
  localparam mode_mask_t MASK_DBL = 9'h004;
  localparam mode_mask_t MASK_BTK = 9'h008;

  // Token kinds
  localparam kind_t KIND_EOF             = 5'd0;
  localparam kind_t KIND_REGULAR         = 5'd1;
  localparam kind_t KIND_ESCAPE          = 5'd2;
  localparam kind_t KIND_SQUOTE          = 5'd3;
  localparam kind_t KIND_BTICK           = 5'd4;
  localparam kind_t KIND_DQUOTE          = 5'd5;
  localparam kind_t KIND_EXP_CLOSE       = 5'd6;
  localparam kind_t KIND_EXP_OPEN        = 5'd7;
  localparam kind_t KIND_ARITH_OPEN      = 5'd8;
  localparam kind_t KIND_ARITH_CLOSE     = 5'd9;
  localparam kind_t KIND_EXP_SUBSH_OPEN  = 5'd10;
  localparam kind_t KIND_EXP_SUBSH_CLOSE = 5'd11;
  localparam kind_t KIND_VARIABLE        = 5'd12;
  localparam kind_t KIND_ARITH_GRP_OPEN  = 5'd13;
  localparam kind_t KIND_ARITH_GRP_CLOSE = 5'd14;
  localparam kind_t KIND_SUBSH_OPEN      = 5'd15;
  localparam kind_t KIND_SUBSH_CLOSE     = 5'd16;

  // Characters that take part in patterns
  localparam char_t CH_SQUOTE = 8'h27;
  localparam char_t CH_DQUOTE = 8'h22;
  localparam char_t CH_BTICK  = 8'h60;
  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_BSLASH = 8'h5C;

  // One window of pending characters with its mode
  typedef struct packed {
    mode_t  mode;
    avail_t avail;
    char_t  c0;
    char_t  c1;
    char_t  c2;
  } window_t;

  // One classified token
  typedef struct packed {
    kind_t  kind;
    count_t count;
  } token_t;

endpackage

// ===== hw/rtl/stok_window_if.sv =====
// ----------------------------------------------------------------------------
// stok_window_if
// Valid/ready channel that carries one character window and its mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stok_window_if;
  logic                   valid;
  logic                   ready;
  stok_pkg::mode_t        current_mode;
  stok_pkg::avail_t       chars_available;
  stok_pkg::char_t        first_char;
  stok_pkg::char_t        second_char;
  stok_pkg::char_t        third_char;

  modport source (
    output valid, current_mode, chars_available, first_char, second_char, third_char,
    input  ready
  );

  modport sink (
    input  valid, current_mode, chars_available, first_char, second_char, third_char,
    output ready
  );
endinterface

// ===== hw/rtl/stok_token_if.sv =====
// ----------------------------------------------------------------------------
// stok_token_if
// Valid/ready channel that carries one classified token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stok_token_if;
  logic                   valid;
  logic                   ready;
  stok_pkg::kind_t        token_kind;
  stok_pkg::count_t       consumed_count;

  modport source (
    output valid, token_kind, consumed_count,
    input  ready
  );

  modport sink (
    input  valid, token_kind, consumed_count,
    output ready
  );
endinterface

// ===== hw/rtl/stok_classify.sv =====
// ----------------------------------------------------------------------------
// stok_classify
// Combinational token classifier: escape rules, then the mode-gated pattern
// list, with partially matched prefix characters kept as consumed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stok_classify (
  input  stok_pkg::window_t win,
  output stok_pkg::token_t  tok
);
  import stok_pkg::*;

  mode_mask_t mb;
  logic       has2;
  logic       has3;
  logic       en_sq;
  logic       en_ns;
  logic       esc;
  logic       c1_starts;

  // Decode the mode into a one-hot mask; codes past the last mode enable nothing
  always_comb begin
    if (win.mode <= MODE_SUB) begin
      mb = mode_mask_t'(1) << win.mode;
    end else begin
      mb = '0;
    end
  end

  assign has2  = (win.avail >= 2'd2);
  assign has3  = (win.avail == 2'd3);
  assign en_sq = |(mb & ~MASK_DBL);
  assign en_ns = |(mb & ~MASK_SGL);

  // Does the second character open any pattern enabled in this mode
  always_comb begin
    case (win.c1)
      CH_SQUOTE: c1_starts = en_sq;
      CH_BTICK,
      CH_DQUOTE,
      CH_DOLLAR: c1_starts = en_ns;
      CH_RBRACE: c1_starts = mb[MODE_EXP];
      CH_RPAREN,
      CH_LPAREN: c1_starts = mb[MODE_ARI] | mb[MODE_AGR] | mb[MODE_ESB]
                             | mb[MODE_UNQ] | mb[MODE_SUB];
      default:   c1_starts = 1'b0;
    endcase
  end

  // Backslash escape rules
  always_comb begin
    if (mb == MASK_SGL) begin
      esc = 1'b0;
    end else if (mb == MASK_UNQ || !has2) begin
      esc = 1'b1;
    end else if (win.c1 == CH_BSLASH) begin
      esc = 1'b1;
    end else if (mb == MASK_BTK) begin
      esc = (win.c1 == CH_DOLLAR) || (win.c1 == CH_BTICK);
    end else begin
      esc = c1_starts;
    end
  end

  // Pick the token kind and the number of characters taken
  always_comb begin
    tok.kind  = KIND_REGULAR;
    tok.count = 2'd1;
    if (win.avail == 2'd0) begin
      tok.kind  = KIND_EOF;
      tok.count = 2'd0;
    end else if (win.c0 == CH_BSLASH) begin
      if (esc) begin
        tok.kind  = KIND_ESCAPE;
        tok.count = has2 ? 2'd2 : 2'd1;
      end
    end else begin
      case (win.c0)
        CH_SQUOTE: if (en_sq) tok.kind = KIND_SQUOTE;
        CH_BTICK:  if (en_ns) tok.kind = KIND_BTICK;
        CH_DQUOTE: if (en_ns) tok.kind = KIND_DQUOTE;
        CH_RBRACE: if (mb[MODE_EXP]) tok.kind = KIND_EXP_CLOSE;
        CH_DOLLAR: begin
          if (en_ns) begin
            if (has2 && win.c1 == CH_LBRACE) begin
              tok.kind  = KIND_EXP_OPEN;
              tok.count = 2'd2;
            end else if (has2 && win.c1 == CH_LPAREN) begin
              // "$(" stays consumed even when the third "(" is missing
              if (has3 && win.c2 == CH_LPAREN) begin
                tok.kind  = KIND_ARITH_OPEN;
                tok.count = 2'd3;
              end else begin
                tok.kind  = KIND_EXP_SUBSH_OPEN;
                tok.count = 2'd2;
              end
            end else begin
              tok.kind = KIND_VARIABLE;
            end
          end
        end
        CH_RPAREN: begin
          if (mb[MODE_ARI]) begin
            if (has2 && win.c1 == CH_RPAREN) begin
              tok.kind  = KIND_ARITH_CLOSE;
              tok.count = 2'd2;
            end
          end else if (mb[MODE_ESB]) begin
            tok.kind = KIND_EXP_SUBSH_CLOSE;
          end else if (mb[MODE_AGR]) begin
            tok.kind = KIND_ARITH_GRP_CLOSE;
          end else if (mb[MODE_UNQ] || mb[MODE_SUB]) begin
            tok.kind = KIND_SUBSH_CLOSE;
          end
        end
        CH_LPAREN: begin
          if (mb[MODE_ARI] || mb[MODE_AGR]) begin
            tok.kind = KIND_ARITH_GRP_OPEN;
          end else if (mb[MODE_UNQ] || mb[MODE_SUB] || mb[MODE_ESB]) begin
            tok.kind = KIND_SUBSH_OPEN;
          end
        end
        default: tok.kind = KIND_REGULAR;
      endcase
    end
  end

endmodule

// ===== hw/rtl/shell_word_char_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// shell_word_char_tokenizer_top
// Shell word tokenizer: classifies one window of up to three characters per
// item into a token kind and a consumed character count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each accepted window item yields exactly one token item; it passes through
// the input register and then the result register, with the classifier
// between them. A new window can be accepted every cycle; the input channel
// stalls only when both registers are full and the token channel is not
// taking the waiting item. The block keeps no state between items.
module shell_word_char_tokenizer_top (
  input  logic          clk,
  input  logic          rst,
  stok_window_if.sink   window,
  stok_token_if.source  token
);
  import stok_pkg::*;

  logic    s1_valid;
  window_t s1_item;
  logic    out_valid;
  token_t  out_item;
  token_t  cls;
  logic    out_load;
  logic    s1_adv;

  // Advance when the result register is empty or being drained
  assign out_load     = !out_valid || token.ready;
  assign s1_adv       = s1_valid && out_load;
  assign window.ready = !s1_valid || out_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (window.ready) begin
      s1_valid <= window.valid;
    end
    if (window.valid && window.ready) begin
      s1_item.mode  <= window.current_mode;
      s1_item.avail <= window.chars_available;
      s1_item.c0    <= window.first_char;
      s1_item.c1    <= window.second_char;
      s1_item.c2    <= window.third_char;
    end
  end

  stok_classify u_classify (
    .win (s1_item),
    .tok (cls)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
    if (s1_adv) begin
      out_item <= cls;
    end
  end

  assign token.valid          = out_valid;
  assign token.token_kind     = out_item.kind;
  assign token.consumed_count = out_item.count;

  // Only end of input consumes nothing
  a_eof_count: assert property (@(posedge clk) disable iff (rst)
    token.valid |-> ((token.token_kind == KIND_EOF) == (token.consumed_count == 2'd0)))
    else $error("token kind and consumed count disagree on end of input");

  // An item leaving the input register shows up as a result next cycle
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> token.valid)
    else $error("item lost between input and result registers");

  // Never consume more characters than the window held
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (token.consumed_count <= $past(s1_item.avail)))
    else $error("consumed count exceeds available characters");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shell word character tokenizer. A short
// directed table covers end of input, the escape rules, every token kind but
// the quote kinds and the backtick kind, and the partial-match cases. A random
// run follows with character windows biased toward pattern characters. Random
// gaps and stalls are applied on both channels, plus one long output hold-off.
// Each token is compared with its table value or with an in-bench classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import stok_pkg::*;

  localparam int RANDOM_ITEMS  = 1650;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT       = 600;
  localparam int STEADY_FIRST  = 1000;
  localparam int STEADY_LAST   = 1200;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int REPORT_LIMIT  = 10;
  localparam int PATTERN_COUNT = 14;

  localparam mode_t MODE_NONE_LO = 4'd9;
  localparam mode_t MODE_NONE_HI = 4'd15;

  localparam mode_mask_t MB_ALL     = '1;
  localparam mode_mask_t MB_NOT_SGL = MB_ALL & ~MASK_SGL;
  localparam mode_mask_t MB_EXP     = mode_mask_t'(1) << MODE_EXP;
  localparam mode_mask_t MB_ARI     = mode_mask_t'(1) << MODE_ARI;
  localparam mode_mask_t MB_AGR     = mode_mask_t'(1) << MODE_AGR;
  localparam mode_mask_t MB_ESB     = mode_mask_t'(1) << MODE_ESB;
  localparam mode_mask_t MB_SUB     = mode_mask_t'(1) << MODE_SUB;

  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_LETTER = 8'h61;
  localparam char_t CH_TOP    = 8'hFF;

  // One fixed pattern of the classifier
  typedef struct packed {
    logic [2:0][CHAR_W-1:0] pat;
    logic [1:0]             len;
    kind_t                  kind;
    mode_mask_t             modes;
  } pattern_t;

  // One row of the directed table
  typedef struct {
    window_t win;
    bit      typed;
    token_t  tok;
  } stim_row_t;

  logic clk;
  logic rst;

  stok_window_if win_if ();
  stok_token_if  tok_if ();

  shell_word_char_tokenizer_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .window (win_if),
    .token  (tok_if)
  );

  token_t    expected_tokens[$];
  token_t    next_token;
  stim_row_t directed_rows[$];
  int        mismatches;
  int        tokens_seen;
  bit        steady_run;
  bit        hold_request;

  // --------------------------------------------------------------------------
  // Classifier
  // --------------------------------------------------------------------------

  function automatic pattern_t make_pattern(char_t a, char_t b, char_t c, int n,
                                            kind_t k, mode_mask_t m);
    pattern_t p;
    p.pat[0] = a;
    p.pat[1] = b;
    p.pat[2] = c;
    p.len    = n[1:0];
    p.kind   = k;
    p.modes  = m;
    return p;
  endfunction

  // Patterns in priority order
  function automatic pattern_t pattern_rule(int idx);
    pattern_t p;
    p = '0;
    case (idx)
      0:  p = make_pattern(CH_SQUOTE, CH_NUL, CH_NUL, 1, KIND_SQUOTE, MB_ALL & ~MASK_DBL);
      1:  p = make_pattern(CH_BTICK, CH_NUL, CH_NUL, 1, KIND_BTICK, MB_NOT_SGL);
      2:  p = make_pattern(CH_DQUOTE, CH_NUL, CH_NUL, 1, KIND_DQUOTE, MB_NOT_SGL);
      3:  p = make_pattern(CH_RBRACE, CH_NUL, CH_NUL, 1, KIND_EXP_CLOSE, MB_EXP);
      4:  p = make_pattern(CH_DOLLAR, CH_LBRACE, CH_NUL, 2, KIND_EXP_OPEN, MB_NOT_SGL);
      5:  p = make_pattern(CH_DOLLAR, CH_LPAREN, CH_LPAREN, 3, KIND_ARITH_OPEN, MB_NOT_SGL);
      6:  p = make_pattern(CH_RPAREN, CH_RPAREN, CH_NUL, 2, KIND_ARITH_CLOSE, MB_ARI);
      7:  p = make_pattern(CH_DOLLAR, CH_LPAREN, CH_NUL, 2, KIND_EXP_SUBSH_OPEN, MB_NOT_SGL);
      8:  p = make_pattern(CH_RPAREN, CH_NUL, CH_NUL, 1, KIND_EXP_SUBSH_CLOSE, MB_ESB);
      9:  p = make_pattern(CH_DOLLAR, CH_NUL, CH_NUL, 1, KIND_VARIABLE, MB_NOT_SGL);
      10: p = make_pattern(CH_LPAREN, CH_NUL, CH_NUL, 1, KIND_ARITH_GRP_OPEN, MB_ARI | MB_AGR);
      11: p = make_pattern(CH_RPAREN, CH_NUL, CH_NUL, 1, KIND_ARITH_GRP_CLOSE, MB_AGR);
      12: p = make_pattern(CH_LPAREN, CH_NUL, CH_NUL, 1, KIND_SUBSH_OPEN,
                           MASK_UNQ | MB_SUB | MB_ESB);
      13: p = make_pattern(CH_RPAREN, CH_NUL, CH_NUL, 1, KIND_SUBSH_CLOSE, MASK_UNQ | MB_SUB);
      default: p = '0;
    endcase
    return p;
  endfunction

  // True when some pattern enabled in this mode begins with c
  function automatic bit opens_pattern(mode_mask_t mb, char_t c);
    pattern_t p;
    for (int r = 0; r < PATTERN_COUNT; r++) begin
      p = pattern_rule(r);
      if ((p.modes & mb) != '0 && p.pat[0] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic token_t classify_window(window_t w);
    mode_mask_t mb;
    char_t      chars [3];
    pattern_t   p;
    token_t     tk;
    bit         esc;
    bit         ok;
    bit         found;
    int         used;
    mb = (w.mode < MODES) ? (mode_mask_t'(1) << w.mode) : '0;
    chars[0] = w.c0;
    chars[1] = w.c1;
    chars[2] = w.c2;
    tk.kind  = KIND_EOF;
    tk.count = '0;
    if (w.avail == 0) return tk;

    // Backslash: escape rules depend on the mode
    if (chars[0] == CH_BSLASH) begin
      if (mb == MASK_SGL) esc = 1'b0;
      else if (mb == MASK_UNQ || w.avail < 2) esc = 1'b1;
      else if (chars[1] == CH_BSLASH) esc = 1'b1;
      else if (mb == MASK_BTK) esc = (chars[1] == CH_DOLLAR || chars[1] == CH_BTICK);
      else esc = opens_pattern(mb, chars[1]);
      if (esc) begin
        tk.kind  = KIND_ESCAPE;
        tk.count = (w.avail >= 2) ? 2'd2 : 2'd1;
      end else begin
        tk.kind  = KIND_REGULAR;
        tk.count = 2'd1;
      end
      return tk;
    end

    // Try patterns in order; matched prefix characters stay consumed
    used    = 1;
    found   = 1'b0;
    tk.kind = KIND_REGULAR;
    for (int r = 0; r < PATTERN_COUNT && !found; r++) begin
      p = pattern_rule(r);
      if ((p.modes & mb) != '0) begin
        ok = 1'b1;
        for (int i = 0; i < p.len && ok; i++) begin
          if (i >= used) begin
            if (i >= w.avail || chars[i] != p.pat[i]) ok = 1'b0;
            else used = i + 1;
          end else if (chars[i] != p.pat[i]) begin
            ok = 1'b0;
          end
        end
        if (ok) begin
          tk.kind = p.kind;
          found   = 1'b1;
        end
      end
    end
    tk.count = used[1:0];
    return tk;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_row(mode_t m, avail_t a, char_t c0, char_t c1, char_t c2,
                         bit typed, kind_t k, count_t n);
    stim_row_t row;
    row.win.mode  = m;
    row.win.avail = a;
    row.win.c0    = c0;
    row.win.c1    = c1;
    row.win.c2    = c2;
    row.typed     = typed;
    row.tok.kind  = k;
    row.tok.count = n;
    directed_rows.push_back(row);
  endtask

  // Mostly pattern characters, sometimes any byte
  function automatic char_t pick_char();
    if ($urandom_range(0, 3) == 0) return char_t'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: return CH_SQUOTE;
      1: return CH_DQUOTE;
      2: return CH_BTICK;
      3: return CH_DOLLAR;
      4: return CH_LBRACE;
      5: return CH_RBRACE;
      6: return CH_LPAREN;
      7: return CH_RPAREN;
      8: return CH_BSLASH;
      default: return CH_LETTER;
    endcase
  endfunction

  function automatic window_t random_window();
    window_t w;
    if ($urandom_range(0, 9) == 0) w.mode = mode_t'($urandom_range(MODE_NONE_LO, MODE_NONE_HI));
    else w.mode = mode_t'($urandom_range(MODE_UNQ, MODE_SUB));
    if ($urandom_range(0, 15) == 0) w.avail = '0;
    else w.avail = avail_t'($urandom_range(1, 3));
    w.c0 = pick_char();
    w.c1 = pick_char();
    w.c2 = pick_char();
    // Shell words often open with a dollar; push the multi-character patterns
    if ($urandom_range(0, 3) == 0) begin
      w.c0 = CH_DOLLAR;
      if ($urandom_range(0, 1) == 0) w.c1 = CH_LPAREN;
    end
    return w;
  endfunction

  // Offer one window after a random gap and hold it until accepted
  task automatic offer_window(window_t w, token_t tok);
    int gap;
    gap = steady_run ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      win_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    win_if.current_mode    = w.mode;
    win_if.chars_available = w.avail;
    win_if.first_char      = w.c0;
    win_if.second_char     = w.c1;
    win_if.third_char      = w.c2;
    next_token             = tok;
    win_if.valid           = 1'b1;
    do @(posedge clk); while (win_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Token receiver: random stall per item, one long hold-off on request
  // --------------------------------------------------------------------------

  initial begin
    int stall;
    tok_if.ready = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = steady_run ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        tok_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      tok_if.ready = 1'b1;
      do @(posedge clk); while (tok_if.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: queue at window acceptance, compare at token acceptance
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    token_t want;
    if (!rst) begin
      if (win_if.valid === 1'b1 && win_if.ready === 1'b1) expected_tokens.push_back(next_token);
      if (tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          note_mismatch($sformatf("token %0d with nothing pending: kind %0d count %0d",
                                  tokens_seen, tok_if.token_kind, tok_if.consumed_count));
        end else begin
          want = expected_tokens.pop_front();
          if (tok_if.token_kind !== want.kind || tok_if.consumed_count !== want.count)
            note_mismatch($sformatf("token %0d: kind exp %0d got %0d, count exp %0d got %0d",
                                    tokens_seen, want.kind, tok_if.token_kind, want.count,
                                    tok_if.consumed_count));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    window_t w;
    int      waited;
    mismatches             = 0;
    tokens_seen            = 0;
    steady_run             = 1'b0;
    hold_request           = 1'b0;
    next_token             = '0;
    win_if.valid           = 1'b0;
    win_if.current_mode    = MODE_UNQ;
    win_if.chars_available = '0;
    win_if.first_char      = CH_NUL;
    win_if.second_char     = CH_NUL;
    win_if.third_char      = CH_NUL;
    rst                    = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // End of input, escapes, all token kinds but the quote and backtick ones, and the partial-match cases
    add_row(MODE_UNQ, 2'd0, CH_DOLLAR, CH_LPAREN, CH_LPAREN, 1'b1, KIND_EOF, 2'd0);
    add_row(MODE_NONE_HI, 2'd0, CH_TOP, CH_TOP, CH_TOP, 1'b1, KIND_EOF, 2'd0);
    add_row(MODE_DBL, 2'd1, CH_BSLASH, CH_BSLASH, CH_NUL, 1'b1, KIND_ESCAPE, 2'd1);
    add_row(MODE_UNQ, 2'd3, CH_BSLASH, CH_LETTER, CH_TOP, 1'b1, KIND_ESCAPE, 2'd2);
    add_row(MODE_SGL, 2'd2, CH_BSLASH, CH_BSLASH, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_BTK, 2'd2, CH_BSLASH, CH_DOLLAR, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_BTK, 2'd3, CH_BSLASH, CH_DQUOTE, CH_LETTER, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_DBL, 2'd2, CH_BSLASH, CH_DQUOTE, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_NONE_LO, 2'd2, CH_BSLASH, CH_BSLASH, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_NONE_HI, 2'd2, CH_BSLASH, CH_DOLLAR, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_UNQ, 2'd3, CH_DOLLAR, CH_LPAREN, CH_LPAREN, 1'b1, KIND_ARITH_OPEN, 2'd3);
    add_row(MODE_UNQ, 2'd3, CH_DOLLAR, CH_LPAREN, CH_LETTER, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_DBL, 2'd2, CH_DOLLAR, CH_LPAREN, CH_LPAREN, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_DBL, 2'd3, CH_DOLLAR, CH_LBRACE, CH_RBRACE, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_EXP, 2'd1, CH_DOLLAR, CH_LBRACE, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_ARI, 2'd2, CH_RPAREN, CH_RPAREN, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_ARI, 2'd3, CH_RPAREN, CH_LETTER, CH_RPAREN, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_AGR, 2'd1, CH_LPAREN, CH_NUL, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_AGR, 2'd2, CH_RPAREN, CH_RPAREN, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_ESB, 2'd1, CH_RPAREN, CH_TOP, CH_TOP, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_SUB, 2'd1, CH_LPAREN, CH_NUL, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_UNQ, 2'd2, CH_RPAREN, CH_DQUOTE, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_EXP, 2'd3, CH_RBRACE, CH_SQUOTE, CH_BTICK, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_DBL, 2'd1, CH_SQUOTE, CH_NUL, CH_NUL, 1'b0, KIND_EOF, 2'd0);
    add_row(MODE_SGL, 2'd3, CH_BTICK, CH_SQUOTE, CH_NUL, 1'b0, KIND_EOF, 2'd0);

    foreach (directed_rows[i])
      offer_window(directed_rows[i].win,
                   directed_rows[i].typed ? directed_rows[i].tok
                                          : classify_window(directed_rows[i].win));

    // Random windows; one long output hold-off and one stretch with no gaps
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) hold_request = 1'b1;
      steady_run = (n >= STEADY_FIRST && n < STEADY_LAST);
      w = random_window();
      offer_window(w, classify_window(w));
    end
    steady_run   = 1'b0;
    win_if.valid = 1'b0;

    // Drain, then let the pipeline settle before the final check
    for (waited = 0; expected_tokens.size() != 0 && waited < DRAIN_LIMIT; waited++)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_tokens.size() != 0)
      note_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/stok_pkg.sv
hw/rtl/stok_window_if.sv
hw/rtl/stok_token_if.sv
hw/rtl/stok_classify.sv
hw/rtl/shell_word_char_tokenizer_top.sv
verif/tb_top.sv
